### rtl/core/counter_priority_task_scheduler_core_macros.svh
// Assertion macros for the scheduler core checker
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_CORE_MACROS_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_CORE_MACROS_SVH

// assert an implication on the next cycle
`define CPTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cpts check failed");

// assert a same-cycle implication
`define CPTS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cpts check failed");

`endif

### rtl/core/cpts_pkg.sv
// ----------------------------------------------------------------------------
// cpts_pkg
// Types and constants shared by the scheduler core and its slot cells.
// ----------------------------------------------------------------------------
package cpts_pkg;

  localparam int unsigned CntW = 9;
  localparam int unsigned PrioW = 8;
  localparam int unsigned SigW = 32;
  localparam logic [CntW-1:0] CntMax = 9'd511;
  localparam logic [SigW-1:0] SigUnblockable = 32'h0004_0100;

  localparam logic [1:0] StRunning = 2'd0;
  localparam logic [1:0] StInterruptible = 2'd1;

  typedef enum logic [2:0] {
    ReqTick = 3'd0,
    ReqSched = 3'd1,
    ReqWrEntry = 3'd2,
    ReqWrSig = 3'd3,
    ReqWake = 3'd4,
    ReqPause = 3'd5
  } req_e;

  // one word carried around the ring
  typedef struct packed {
    logic             present;
    logic [1:0]       run_state;
    logic [CntW-1:0]  counter;
    logic [PrioW-1:0] priority_v;
    logic [SigW-1:0]  pending;
    logic [SigW-1:0]  blocked;
  } slot_t;

  // per-shift operation applied by the head stage
  typedef struct packed {
    logic wake_sig;
    logic recompute;
  } slot_op_t;

endpackage

### rtl/core/cpts_cell.sv
// ----------------------------------------------------------------------------
// cpts_cell
// One stage of the rotating slot ring: holds a slot word, passes it on.
// ----------------------------------------------------------------------------
module cpts_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  cpts_pkg::slot_t rst_val_i,
  input  cpts_pkg::slot_t slot_i,
  output cpts_pkg::slot_t slot_o
);
  import cpts_pkg::*;

  slot_t slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= rst_val_i;
    end else if (shift_i) begin
      slot_q <= slot_i;
    end
  end

  assign slot_o = slot_q;

endmodule

### rtl/core/cpts_head.sv
// ----------------------------------------------------------------------------
// cpts_head
// Ring entry logic: signal wakeup and counter recompute on the passing word.
// ----------------------------------------------------------------------------
module cpts_head (
  input  cpts_pkg::slot_t   slot_i,
  input  cpts_pkg::slot_op_t op_i,
  output cpts_pkg::slot_t   slot_o
);
  import cpts_pkg::*;

  logic [CntW:0] sum;

  always_comb begin
    slot_o = slot_i;
    sum = {2'b0, slot_i.counter[CntW-1:1]} + {2'b0, slot_i.priority_v};
    if (op_i.wake_sig && slot_i.present && slot_i.run_state == StInterruptible &&
        (slot_i.pending & ~(slot_i.blocked & ~SigUnblockable)) != '0) begin
      slot_o.run_state = StRunning;
    end
    if (op_i.recompute && slot_i.present) begin
      slot_o.counter = (sum > {1'b0, CntMax}) ? CntMax : sum[CntW-1:0];
    end
  end

endmodule

### rtl/core/counter_priority_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler_core
// Time-slice counter scheduler over a rotating ring of task slot cells.
// ----------------------------------------------------------------------------
// Usage: present one request word on the in channel (in_valid_i, in_stall_o)
// and take one result word from the out channel (out_valid_o, out_stall_i).
// Slots live in a ring of TASK_SLOTS cells; every operation rotates the ring
// by one slot per cycle while a pass runs, and a full rotation brings slot 0
// back to the head. Each pass shifts all TASK_SLOTS slots past the head and
// ends in a check state. A write, wake, rejected word or tick without reload
// runs one pass before out_valid_o rises. A schedule runs the edit, wake and
// pick passes, plus two more passes (recompute and repick) when the best
// runnable counter is zero. One word is handled at a time, and the next word
// is taken in the idle state that follows the result leaving.
// At reset the ring loads task 0 present with counter and priority 15, all
// other slots empty with priority 1, and the running task is 0.
// The result sits in an output register; while out_stall_i is high it is
// held and no new request is taken.
// ----------------------------------------------------------------------------
module counter_priority_task_scheduler_core #(
  parameter int unsigned TASK_SLOTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] req_type_i,
  input  logic [5:0] task_index_i,
  input  logic       present_i,
  input  logic [1:0] run_state_i,
  input  logic [7:0] priority_req_i,
  input  logic [8:0] counter_value_i,
  input  logic [31:0] pending_signals_i,
  input  logic [31:0] blocked_signals_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] current_task_o,
  output logic       switched_o,
  output logic [8:0] chosen_counter_o,
  output logic       status_o
);
  import cpts_pkg::*;

  localparam int unsigned IdxW = $clog2(TASK_SLOTS);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StPass  = 5'b00010,
    StCheck = 5'b00100,
    StEnd   = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  // pass kinds
  localparam logic [1:0] PkEdit = 2'd0;
  localparam logic [1:0] PkWake = 2'd1;
  localparam logic [1:0] PkPick = 2'd2;
  localparam logic [1:0] PkRecomp = 2'd3;

  state_e state_q, state_d;
  logic [1:0] kind_q, kind_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [IdxW-1:0] run_q, run_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic [CntW:0] best_q, best_d;
  logic recomp_done_q, recomp_done_d;
  logic sched_q, sched_d;
  logic status_q, status_d;
  logic [2:0] req_q;
  logic [IdxW-1:0] idx_q;
  logic pres_q;
  logic [1:0] rs_q;
  logic [PrioW-1:0] prio_q;
  logic [CntW-1:0] cnt_q;
  logic [SigW-1:0] pend_q, blk_q;
  logic [5:0] cur_out_q;
  logic [CntW-1:0] cnt_out_q;
  logic out_valid_q;

  slot_t ring [TASK_SLOTS];
  slot_t head_in, head_out, edited;
  slot_op_t op;
  logic shift;
  logic accept;
  logic [IdxW-1:0] slot_no;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign shift = (state_q == StPass);
  // ring[0] holds slot pos_q
  assign slot_no = pos_q;
  assign head_in = ring[0];

  assign op.wake_sig = (kind_q == PkWake) && (slot_no != '0);
  assign op.recompute = (kind_q == PkRecomp) && (slot_no != '0);

  cpts_head u_head (
    .slot_i(head_in),
    .op_i  (op),
    .slot_o(head_out)
  );

  always_comb begin
    edited = head_out;
    if (kind_q == PkEdit) begin
      if (req_q == ReqTick && slot_no == run_q) begin
        if (head_in.counter > 9'd1) begin
          edited.counter = head_in.counter - 9'd1;
        end else begin
          edited.counter = {1'b0, head_in.priority_v};
        end
      end
      if (req_q == ReqPause && slot_no == run_q) begin
        edited.run_state = StInterruptible;
      end
      if (!status_q && slot_no == idx_q) begin
        if (req_q == ReqWrEntry) begin
          edited.present = pres_q;
          edited.run_state = rs_q;
          edited.priority_v = prio_q;
          edited.counter = cnt_q;
        end
        if (req_q == ReqWrSig) begin
          edited.pending = pend_q;
          edited.blocked = blk_q;
        end
        if (req_q == ReqWake) begin
          edited.run_state = StRunning;
        end
      end
    end
  end

  for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
    slot_t rv;
    always_comb begin
      rv = '0;
      rv.priority_v = 8'd1;
      if (g == 0) begin
        rv.present = 1'b1;
        rv.counter = 9'd15;
        rv.priority_v = 8'd15;
      end
    end
    cpts_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .rst_val_i(rv),
      .slot_i   ((g == TASK_SLOTS - 1) ? edited : ring[(g + 1) % TASK_SLOTS]),
      .slot_o   (ring[g])
    );
  end

  always_comb begin
    state_d = state_q;
    kind_d = kind_q;
    pos_d = pos_q;
    run_d = run_q;
    best_idx_d = best_idx_q;
    best_d = best_q;
    recomp_done_d = recomp_done_q;
    sched_d = sched_q;
    status_d = status_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StPass;
          kind_d = PkEdit;
          pos_d = '0;
          recomp_done_d = 1'b0;
          status_d = 1'b0;
          sched_d = 1'b0;
          case (req_type_i)
            ReqTick: sched_d = (ring[run_q].counter <= 9'd1);
            ReqSched: sched_d = 1'b1;
            ReqWrEntry: status_d = ({26'd0, task_index_i} >= 32'(TASK_SLOTS)) ||
                                   (priority_req_i == 8'd0);
            ReqWrSig, ReqWake: status_d = ({26'd0, task_index_i} >= 32'(TASK_SLOTS));
            ReqPause: sched_d = 1'b1;
            default: status_d = 1'b1;
          endcase
        end
      end
      StPass: begin
        if (kind_q == PkPick && slot_no != '0 && head_out.present &&
            head_out.run_state == StRunning &&
            ({1'b0, head_out.counter} >= best_q || best_q[CntW])) begin
          best_d = {1'b0, head_out.counter};
          best_idx_d = slot_no;
        end
        pos_d = (slot_no == IdxW'(TASK_SLOTS - 1)) ? '0 : slot_no + 1'b1;
        if (slot_no == IdxW'(TASK_SLOTS - 1)) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        state_d = StPass;
        case (kind_q)
          PkEdit: begin
            if (sched_q) begin
              kind_d = PkWake;
            end else begin
              state_d = StEnd;
            end
          end
          PkWake, PkRecomp: begin
            kind_d = PkPick;
            best_d = {1'b1, {CntW{1'b0}}};
            best_idx_d = '0;
          end
          PkPick: begin
            if (best_q == '0 && !recomp_done_q) begin
              kind_d = PkRecomp;
              recomp_done_d = 1'b1;
            end else begin
              run_d = best_idx_q;
              state_d = StEnd;
            end
          end
          default: state_d = StEnd;
        endcase
      end
      StEnd: state_d = StOut;
      StOut: begin
        if (!out_stall_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      kind_q <= PkEdit;
      pos_q <= '0;
      run_q <= '0;
      best_idx_q <= '0;
      best_q <= '0;
      recomp_done_q <= 1'b0;
      sched_q <= 1'b0;
      status_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q <= kind_d;
      pos_q <= pos_d;
      run_q <= run_d;
      best_idx_q <= best_idx_d;
      best_q <= best_d;
      recomp_done_q <= recomp_done_d;
      sched_q <= sched_d;
      status_q <= status_d;
      out_valid_q <= (state_d == StOut);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      idx_q <= task_index_i[IdxW-1:0];
      pres_q <= present_i;
      rs_q <= run_state_i;
      prio_q <= priority_req_i;
      cnt_q <= counter_value_i;
      pend_q <= pending_signals_i;
      blk_q <= blocked_signals_i;
    end
    if (state_q == StEnd) begin
      cur_out_q <= 6'(run_q);
      cnt_out_q <= ring[run_q].counter;
    end
  end

  assign out_valid_o = out_valid_q;
  assign current_task_o = cur_out_q;
  assign switched_o = sched_q;
  assign chosen_counter_o = cnt_out_q;
  assign status_o = status_q;

endmodule

### rtl/core/cpts_checker.sv
// ----------------------------------------------------------------------------
// cpts_checker
// Port-level checks on the scheduler core's handshakes and results.
// ----------------------------------------------------------------------------
`include "counter_priority_task_scheduler_core_macros.svh"
module cpts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [5:0] current_task_o,
  input logic       switched_o,
  input logic       status_o
);
  `CPTS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(current_task_o))
  `CPTS_ASSERT_NOW(a_busy_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  `CPTS_ASSERT_NOW(a_rej_noswitch, clk_i, rst_ni, out_valid_o && status_o, !switched_o)
  `CPTS_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o,
    in_stall_o && !out_valid_o)
endmodule

bind counter_priority_task_scheduler_core cpts_checker u_cpts_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .current_task_o(current_task_o), .switched_o(switched_o), .status_o(status_o)
);
